// ===== hw/rtl/ttpr_pkg.sv =====
package ttpr_pkg;

    localparam int INDEX_BITS_DEF = 10;
    localparam int MAX_PROBES_DEF = 8;

    localparam int CMD_W   = 2;
    localparam int LOCK_W  = 32;
    localparam int INFO_W  = 8;
    localparam int DEPTH_W = 8;
    localparam int AGE_W   = 8;
    localparam int BOUND_W = 2;
    localparam int SCORE_W = 16;
    localparam int MOVE_W  = 16;
    localparam int HASH_W  = 64;
    localparam int MAXP_W  = 4;

    localparam logic [MAXP_W-1:0]  MAXP_RESET  = 4'd4;
    localparam logic [BOUND_W-1:0] BOUND_NOUSE = 2'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_FIRST,
        ST_PROBE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [LOCK_W-1:0] lock;
        logic [INFO_W-1:0] info;
    } slot_key_t;

    typedef struct packed {
        logic [DEPTH_W-1:0]        depth;
        logic [AGE_W-1:0]          age;
        logic [BOUND_W-1:0]        bound;
        logic signed [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]         move;
    } slot_data_t;

    typedef struct packed {
        slot_key_t  key;
        slot_data_t data;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // Verdict of the compare unit on the slot that was just read.
    typedef struct packed {
        logic lock_zero;
        logic key_match;
        logic depth_reach;
        logic take;
    } probe_eval_t;

    typedef struct packed {
        logic                      success;
        logic                      usable;
        logic signed [SCORE_W-1:0] score;
        logic [BOUND_W-1:0]        bound;
        logic [DEPTH_W-1:0]        depth;
        logic [AGE_W-1:0]          age;
        logic [MOVE_W-1:0]         move;
    } result_t;

endpackage

// ===== hw/rtl/ttpr_ram.sv =====
module ttpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ttpr_probe_eval.sv =====
module ttpr_probe_eval (
    input  ttpr_pkg::slot_t              slot,
    input  ttpr_pkg::slot_key_t          qkey,
    input  logic [ttpr_pkg::DEPTH_W-1:0] qdepth,
    input  logic [ttpr_pkg::AGE_W-1:0]   search_age,
    output ttpr_pkg::probe_eval_t        verdict
);

    logic slot_empty;

    // An insert may take a slot that is empty, that holds the same position
    // no deeper than the new entry, or that is older than the current search.
    assign slot_empty          = (slot.data.depth == '0);
    assign verdict.lock_zero   = (slot.key.lock == '0);
    assign verdict.key_match   = (slot.key == qkey);
    assign verdict.depth_reach = (slot.data.depth >= qdepth);
    assign verdict.take        = slot_empty
                               || (verdict.key_match && (slot.data.depth <= qdepth))
                               || (slot.data.age < search_age);

endmodule

// ===== hw/rtl/ttpr_seq.sv =====
module ttpr_seq #(
    parameter int INDEX_BITS = ttpr_pkg::INDEX_BITS_DEF,
    parameter int MAX_PROBES = ttpr_pkg::MAX_PROBES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request side
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic [ttpr_pkg::CMD_W-1:0]        req_cmd,
    input  logic [INDEX_BITS-1:0]             req_index,
    input  ttpr_pkg::slot_key_t               req_key,
    input  ttpr_pkg::slot_data_t              req_data,
    input  logic [ttpr_pkg::AGE_W-1:0]        req_search_age,
    // Configuration
    input  logic                              cfg_wr_en,
    input  logic [ttpr_pkg::MAXP_W-1:0]       cfg_wr_data,
    // Table memory
    output logic                              ram_we,
    output logic [INDEX_BITS-1:0]             ram_waddr,
    output ttpr_pkg::slot_t                   ram_wdata,
    output logic [INDEX_BITS-1:0]             ram_raddr,
    input  ttpr_pkg::slot_t                   ram_rdata,
    // Compare unit
    output ttpr_pkg::slot_key_t               eval_key,
    output logic [ttpr_pkg::DEPTH_W-1:0]      eval_depth,
    output logic [ttpr_pkg::AGE_W-1:0]        eval_search_age,
    input  ttpr_pkg::probe_eval_t             verdict,
    // Result side
    output logic                              res_valid,
    input  logic                              res_ready,
    output ttpr_pkg::result_t                 res
);

    localparam int PCW = $clog2(MAX_PROBES + 1);

    ttpr_pkg::state_t     state_reg, state_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic [PCW-1:0]        cnt_reg, cnt_next;
    logic [INDEX_BITS-1:0] sweep_reg, sweep_next;
    logic                  sweep_cmd_reg, sweep_cmd_next;
    logic [ttpr_pkg::MAXP_W-1:0] max_probes_reg;

    logic [ttpr_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    ttpr_pkg::slot_key_t          qkey_reg, qkey_next;
    ttpr_pkg::slot_data_t         qdata_reg, qdata_next;
    logic [ttpr_pkg::AGE_W-1:0]   search_age_reg, search_age_next;
    logic [INDEX_BITS-1:0]        shallow_idx_reg, shallow_idx_next;
    logic [ttpr_pkg::DEPTH_W-1:0] shallow_depth_reg, shallow_depth_next;
    ttpr_pkg::result_t            res_reg, res_next;
    ttpr_pkg::result_t            out_reg, out_next;
    logic                         out_valid_reg, out_valid_next;

    logic [PCW-1:0] probe_lim;
    logic           accept;
    logic           is_insert;
    logic           last_probe;
    logic           probe_stop;
    logic           better;

    // Register values above the synthesized probe limit act as the limit.
    assign probe_lim = ({28'd0, max_probes_reg} > MAX_PROBES) ? PCW'(MAX_PROBES)
                                                              : PCW'(max_probes_reg);

    assign accept     = req_valid && req_ready;
    assign req_ready  = (state_reg == ttpr_pkg::ST_IDLE);
    assign is_insert  = (cmd_reg == ttpr_pkg::CMD_INSERT);
    assign last_probe = ((PCW+1)'(cnt_reg) + (PCW+1)'(1)) == (PCW+1)'(probe_lim);
    assign probe_stop = is_insert ? (verdict.take || last_probe)
                                  : (verdict.lock_zero || verdict.key_match || last_probe);
    assign better     = (cnt_reg == '0) || (ram_rdata.data.depth < shallow_depth_reg);

    assign eval_key        = qkey_reg;
    assign eval_depth      = qdata_reg.depth;
    assign eval_search_age = search_age_reg;

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ttpr_pkg::ST_SWEEP;
            sweep_reg      <= '0;
            sweep_cmd_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            max_probes_reg <= ttpr_pkg::MAXP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            sweep_cmd_reg <= sweep_cmd_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                max_probes_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg           <= idx_next;
        cnt_reg           <= cnt_next;
        cmd_reg           <= cmd_next;
        qkey_reg          <= qkey_next;
        qdata_reg         <= qdata_next;
        search_age_reg    <= search_age_next;
        shallow_idx_reg   <= shallow_idx_next;
        shallow_depth_reg <= shallow_depth_next;
        res_reg           <= res_next;
        out_reg           <= out_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ttpr_pkg::ST_SWEEP:
            begin
                if (sweep_reg == '1)
                begin
                    state_next = sweep_cmd_reg ? ttpr_pkg::ST_DONE : ttpr_pkg::ST_IDLE;
                end
            end
            ttpr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (ttpr_pkg::cmd_t'(req_cmd))
                        ttpr_pkg::CMD_INSERT, ttpr_pkg::CMD_LOOKUP:
                            state_next = (probe_lim == '0) ? ttpr_pkg::ST_DONE
                                                           : ttpr_pkg::ST_FIRST;
                        ttpr_pkg::CMD_CLEAR:
                            state_next = ttpr_pkg::ST_SWEEP;
                        default:
                            state_next = ttpr_pkg::ST_DONE;
                    endcase
                end
            end
            ttpr_pkg::ST_FIRST:
            begin
                state_next = ttpr_pkg::ST_PROBE;
            end
            ttpr_pkg::ST_PROBE:
            begin
                if (probe_stop)
                begin
                    state_next = ttpr_pkg::ST_DONE;
                end
            end
            ttpr_pkg::ST_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    state_next = ttpr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ttpr_pkg::ST_SWEEP;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        idx_next           = idx_reg;
        cnt_next           = cnt_reg;
        sweep_next         = sweep_reg;
        sweep_cmd_next     = sweep_cmd_reg;
        cmd_next           = cmd_reg;
        qkey_next          = qkey_reg;
        qdata_next         = qdata_reg;
        search_age_next    = search_age_reg;
        shallow_idx_next   = shallow_idx_reg;
        shallow_depth_next = shallow_depth_reg;
        res_next           = res_reg;
        out_next           = out_reg;
        out_valid_next     = out_valid_reg;
        ram_we             = 1'b0;
        ram_waddr          = idx_reg;
        ram_wdata          = '{key: qkey_reg, data: qdata_reg};
        // While probing, the next slot is fetched ahead of the compare.
        ram_raddr          = (state_reg == ttpr_pkg::ST_PROBE) ? idx_reg + 1'b1 : idx_reg;

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ttpr_pkg::ST_SWEEP:
            begin
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                ram_wdata  = '0;
                sweep_next = sweep_reg + 1'b1;
            end
            ttpr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = req_cmd;
                    qkey_next       = req_key;
                    qdata_next      = req_data;
                    search_age_next = req_search_age;
                    idx_next        = req_index;
                    cnt_next        = '0;
                    sweep_next      = '0;
                    sweep_cmd_next  = 1'b1;
                    res_next        = '0;
                    res_next.success = (req_cmd == ttpr_pkg::CMD_CLEAR);
                end
            end
            ttpr_pkg::ST_FIRST:
            begin
            end
            ttpr_pkg::ST_PROBE:
            begin
                if (is_insert)
                begin
                    if (verdict.take)
                    begin
                        ram_we           = 1'b1;
                        ram_waddr        = idx_reg;
                        res_next.success = 1'b1;
                    end
                    else if (last_probe)
                    begin
                        // No suitable slot: replace the shallowest one seen,
                        // the earliest on a tie.
                        ram_we           = 1'b1;
                        ram_waddr        = better ? idx_reg : shallow_idx_reg;
                        res_next.success = 1'b1;
                    end
                    if (better)
                    begin
                        shallow_idx_next   = idx_reg;
                        shallow_depth_next = ram_rdata.data.depth;
                    end
                end
                else if (!verdict.lock_zero && verdict.key_match)
                begin
                    res_next.success = 1'b1;
                    res_next.move    = ram_rdata.data.move;
                    if (verdict.depth_reach)
                    begin
                        res_next.usable = 1'b1;
                        res_next.score  = ram_rdata.data.score;
                        res_next.bound  = ram_rdata.data.bound;
                        res_next.depth  = ram_rdata.data.depth;
                        res_next.age    = ram_rdata.data.age;
                    end
                    else
                    begin
                        res_next.bound = ttpr_pkg::BOUND_NOUSE;
                    end
                end
                idx_next = idx_reg + 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            ttpr_pkg::ST_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/transposition_table_probe_replace.sv =====
// Hashed position table with linear probing. Each request on the slave
// stream carries a command in s_tuser: insert, lookup or clear. Insert and
// lookup start at the slot given by the low INDEX_BITS bits of the hash and
// read one slot per cycle, wrapping at the end of the table, for at most
// max_probes slots (values above MAX_PROBES act as MAX_PROBES). An insert
// writes the first suitable slot, or failing that the shallowest probed one;
// it fails only when max_probes is zero. A lookup stops at an empty lock and
// reports a match in full only if the stored depth reaches the query depth,
// else just the move with bound code 3 and usable clear. An insert or lookup
// first reads its start slot, then compares one slot at a time, then loads
// the result register once it is free; with zero probes it goes straight to
// loading the result. The table memory has a single read port. A clear walks
// every slot once, writing one per cycle. The same walk runs once after
// reset, so s_tready stays low until it ends. The block takes one request
// at a time; a finished result waits in the output register, and the next
// request can be accepted while it does. max_probes is written through
// cfg_wr_en and cfg_wr_data; the user must write it only while the block is
// idle, as the block itself does not enforce this.
module transposition_table_probe_replace #(
    parameter int INDEX_BITS = ttpr_pkg::INDEX_BITS_DEF,
    parameter int MAX_PROBES = ttpr_pkg::MAX_PROBES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // hash_key[63:0], entry_lock[95:64], info_bits[103:96],
    // search_depth[111:104], entry_age[119:112], bound_kind[121:120],
    // score_value[137:122], move_code[153:138], search_age[161:154], zero pad
    input  logic [167:0] s_tdata,
    // command[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // found_score[15:0], found_bound[17:16], found_depth[25:18],
    // found_age[33:26], found_move[49:34], zero pad
    output logic [55:0]  m_tdata,
    // success[0], usable[1]
    output logic [1:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [3:0]   cfg_wr_data
);

    ttpr_pkg::slot_key_t           req_key;
    ttpr_pkg::slot_data_t          req_data;
    logic                          ram_we;
    logic [INDEX_BITS-1:0]         ram_waddr;
    logic [INDEX_BITS-1:0]         ram_raddr;
    ttpr_pkg::slot_t               ram_wdata;
    ttpr_pkg::slot_t               ram_rdata;
    ttpr_pkg::slot_key_t           eval_key;
    logic [ttpr_pkg::DEPTH_W-1:0]  eval_depth;
    logic [ttpr_pkg::AGE_W-1:0]    eval_search_age;
    ttpr_pkg::probe_eval_t         verdict;
    ttpr_pkg::result_t             res;

    // The stored key is the lock with the info bits below it; the stored data
    // is depth, age, bound, score and move from the top down.
    assign req_key.lock   = s_tdata[95:64];
    assign req_key.info   = s_tdata[103:96];
    assign req_data.depth = s_tdata[111:104];
    assign req_data.age   = s_tdata[119:112];
    assign req_data.bound = s_tdata[121:120];
    assign req_data.score = s_tdata[137:122];
    assign req_data.move  = s_tdata[153:138];

    ttpr_ram #(
        .WIDTH (ttpr_pkg::SLOT_W),
        .DEPTH (2 ** INDEX_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // One compare unit judges every slot that a probe reads.
    ttpr_probe_eval u_eval (
        .slot       (ram_rdata),
        .qkey       (eval_key),
        .qdepth     (eval_depth),
        .search_age (eval_search_age),
        .verdict    (verdict)
    );

    ttpr_seq #(
        .INDEX_BITS (INDEX_BITS),
        .MAX_PROBES (MAX_PROBES)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (s_tvalid),
        .req_ready       (s_tready),
        .req_cmd         (s_tuser),
        .req_index       (s_tdata[INDEX_BITS-1:0]),
        .req_key         (req_key),
        .req_data        (req_data),
        .req_search_age  (s_tdata[161:154]),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata),
        .eval_key        (eval_key),
        .eval_depth      (eval_depth),
        .eval_search_age (eval_search_age),
        .verdict         (verdict),
        .res_valid       (m_tvalid),
        .res_ready       (m_tready),
        .res             (res)
    );

    assign m_tdata = {6'd0, res.move, res.age, res.depth, res.bound, res.score};
    assign m_tuser = {res.usable, res.success};

    // A request is worked on alone: the block is busy right after accepting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while a previous one is in work");

    // The table is written only by the sweep or a probe, never while idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !s_tready)
        else $error("table write while idle");

    // A new result only appears when the sequencer has finished a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised without a request in work");

    // A usable lookup result is always a successful one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tuser[0])
        else $error("usable result without success");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import ttpr_pkg::*;

    localparam int INDEX_BITS  = INDEX_BITS_DEF;
    localparam int MAX_PROBES  = MAX_PROBES_DEF;
    localparam int TABLE_SIZE  = 1 << INDEX_BITS;
    // A clear walks the whole table; allow several of those without progress.
    localparam int QUIET_LIMIT = 4 * (TABLE_SIZE + 2);
    localparam int TAIL_CYCLES = 2 * (MAX_PROBES + 3);
    localparam int POOL_SIZE   = 24;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 236;

    // Command code 3 is not defined by the package; the block must ignore it.
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    // One request as it travels on the slave stream.
    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic [HASH_W-1:0]         hash;
        logic [LOCK_W-1:0]         lock;
        logic [INFO_W-1:0]         info;
        logic [DEPTH_W-1:0]        depth;
        logic [AGE_W-1:0]          age;
        logic [BOUND_W-1:0]        bound;
        logic signed [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]         move;
        logic [AGE_W-1:0]          search_age;
    } tt_request_t;

    // Shadow copy of the position table. Every accepted request updates the
    // copy and queues the result that the block must return for it.
    class probe_table_model;
        slot_key_t         slot_keys [TABLE_SIZE];
        slot_data_t        slot_vals [TABLE_SIZE];
        logic [MAXP_W-1:0] probe_limit;
        result_t           expected_results [$];
        int unsigned       mismatches;

        function new();
            wipe_slots();
            probe_limit = MAXP_RESET;
            mismatches  = 0;
        endfunction

        function void wipe_slots();
            foreach (slot_keys[i])
            begin
                slot_keys[i] = '0;
                slot_vals[i] = '0;
            end
        endfunction

        function void set_probe_limit(logic [MAXP_W-1:0] value);
            probe_limit = value;
        endfunction

        function int unsigned outstanding();
            return expected_results.size();
        endfunction

        function void note_request(tt_request_t rq);
            result_t               res;
            slot_key_t             key;
            slot_data_t            data;
            logic [INDEX_BITS-1:0] idx;
            logic [INDEX_BITS-1:0] shallow_idx;
            logic [DEPTH_W-1:0]    sd;
            logic [DEPTH_W-1:0]    shallow_depth;
            bit                    have_shallow;
            bit                    done;
            int unsigned           probes;

            res           = '0;
            key           = {rq.lock, rq.info};
            data          = {rq.depth, rq.age, rq.bound, rq.score, rq.move};
            have_shallow  = 0;
            done          = 0;
            shallow_idx   = '0;
            shallow_depth = '0;
            probes        = (probe_limit > MAX_PROBES) ? MAX_PROBES : probe_limit;

            case (rq.cmd)
                CMD_INSERT:
                begin
                    for (int i = 0; i < probes && !done; i++)
                    begin
                        idx = rq.hash[INDEX_BITS-1:0] + INDEX_BITS'(i);
                        sd  = slot_vals[idx].depth;
                        // Empty slot, same position no deeper, or a stale entry.
                        if (sd == 0 || (slot_keys[idx] == key && sd <= rq.depth) ||
                            slot_vals[idx].age < rq.search_age)
                        begin
                            slot_keys[idx] = key;
                            slot_vals[idx] = data;
                            res.success    = 1'b1;
                            done           = 1;
                        end
                        else if (!have_shallow || sd < shallow_depth)
                        begin
                            have_shallow  = 1;
                            shallow_idx   = idx;
                            shallow_depth = sd;
                        end
                    end
                    // Nothing suitable: the shallowest probed slot gives way.
                    if (!done && have_shallow)
                    begin
                        slot_keys[shallow_idx] = key;
                        slot_vals[shallow_idx] = data;
                        res.success            = 1'b1;
                    end
                end
                CMD_LOOKUP:
                begin
                    for (int i = 0; i < probes && !done; i++)
                    begin
                        idx = rq.hash[INDEX_BITS-1:0] + INDEX_BITS'(i);
                        if (slot_keys[idx].lock == '0)
                            done = 1;
                        else if (slot_keys[idx] == key)
                        begin
                            done        = 1;
                            res.success = 1'b1;
                            res.move    = slot_vals[idx].move;
                            if (slot_vals[idx].depth >= rq.depth)
                            begin
                                res.usable = 1'b1;
                                res.score  = slot_vals[idx].score;
                                res.bound  = slot_vals[idx].bound;
                                res.depth  = slot_vals[idx].depth;
                                res.age    = slot_vals[idx].age;
                            end
                            else
                            begin
                                res.bound = BOUND_NOUSE;
                            end
                        end
                    end
                end
                CMD_CLEAR:
                begin
                    wipe_slots();
                    res.success = 1'b1;
                end
                default:
                begin
                end
            endcase
            expected_results.push_back(res);
        endfunction

        function void check_result(result_t got);
            result_t want;

            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got.success !== want.success)
            begin
                $error("success: expected %0d, actual %0d", want.success, got.success);
                mismatches++;
            end
            if (got.usable !== want.usable)
            begin
                $error("usable: expected %0d, actual %0d", want.usable, got.usable);
                mismatches++;
            end
            if (got.score !== want.score)
            begin
                $error("found_score: expected %0d, actual %0d", want.score, got.score);
                mismatches++;
            end
            if (got.bound !== want.bound)
            begin
                $error("found_bound: expected %0d, actual %0d", want.bound, got.bound);
                mismatches++;
            end
            if (got.depth !== want.depth)
            begin
                $error("found_depth: expected %0d, actual %0d", want.depth, got.depth);
                mismatches++;
            end
            if (got.age !== want.age)
            begin
                $error("found_age: expected %0d, actual %0d", want.age, got.age);
                mismatches++;
            end
            if (got.move !== want.move)
            begin
                $error("found_move: expected %0d, actual %0d", want.move, got.move);
                mismatches++;
            end
        endfunction
    endclass

    logic         clk         = 1'b0;
    logic         rst_n       = 1'b0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata     = '0;
    logic [1:0]   s_tuser     = '0;
    logic         m_tvalid;
    logic         m_tready    = 1'b0;
    logic [55:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_wr_en   = 1'b0;
    logic [3:0]   cfg_wr_data = '0;

    // When clear, neither side inserts idle cycles.
    bit           idle_on     = 1'b1;
    logic [7:0]   cur_age     = 8'd0;

    // A small set of positions whose start slots crowd together around the
    // end of the table, so probe chains collide, fill up and wrap.
    logic [HASH_W-1:0] pool_hash [POOL_SIZE];
    logic [LOCK_W-1:0] pool_lock [POOL_SIZE];
    logic [INFO_W-1:0] pool_info [POOL_SIZE];

    probe_table_model table_model = new();

    always #5 clk = ~clk;

    transposition_table_probe_replace u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Result side: check every accepted result, then pick the next ready.
    always @(posedge clk)
    begin
        result_t got;

        if (m_tvalid && m_tready)
        begin
            got.success = m_tuser[0];
            got.usable  = m_tuser[1];
            got.score   = m_tdata[15:0];
            got.bound   = m_tdata[17:16];
            got.depth   = m_tdata[25:18];
            got.age     = m_tdata[33:26];
            got.move    = m_tdata[49:34];
            table_model.check_result(got);
        end
        m_tready <= rst_n && (!idle_on || $urandom_range(0, 99) >= 23);
    end

    // Watchdog: ends the run when nothing moves on either stream for too long.
    initial
    begin
        int unsigned quiet;

        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[transposition_table_probe_replace] ERROR");
        $finish;
    end

    // Present one request, with random idle cycles ahead of it, and hold it
    // until the block takes it. Valid stays high on return so that a request
    // that follows at once goes out without a gap.
    task automatic send_request(tt_request_t rq);
        while (idle_on && $urandom_range(0, 99) < 23)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.cmd;
        s_tdata  <= {6'b0, rq.search_age, rq.move, rq.score, rq.bound, rq.age,
                     rq.depth, rq.info, rq.lock, rq.hash};
        do
            @(posedge clk);
        while (!s_tready);
        table_model.note_request(rq);
    endtask

    // Stop sending and wait until every outstanding result is back and the
    // block is ready for a new request.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (table_model.outstanding() != 0 || !s_tready)
            @(posedge clk);
    endtask

    task automatic write_probe_limit(logic [3:0] value);
        wait_results_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        table_model.set_probe_limit(value);
    endtask

    function automatic tt_request_t make_request(
        logic [CMD_W-1:0] cmd, logic [HASH_W-1:0] hash, logic [LOCK_W-1:0] lock,
        logic [INFO_W-1:0] info, logic [DEPTH_W-1:0] depth, logic [AGE_W-1:0] age,
        logic [BOUND_W-1:0] bound, logic [SCORE_W-1:0] score,
        logic [MOVE_W-1:0] move, logic [AGE_W-1:0] search_age);
        tt_request_t rq;

        rq.cmd        = cmd;
        rq.hash       = hash;
        rq.lock       = lock;
        rq.info       = info;
        rq.depth      = depth;
        rq.age        = age;
        rq.bound      = bound;
        rq.score      = score;
        rq.move       = move;
        rq.search_age = search_age;
        return rq;
    endfunction

    // Mostly inserts and lookups on the crowded positions, with a few clears,
    // near misses on the identity bits, fully random requests and unknown
    // commands mixed in.
    function automatic tt_request_t random_request();
        tt_request_t rq;
        int unsigned pick;
        int unsigned sel;

        pick          = $urandom_range(0, 99);
        sel           = $urandom_range(0, POOL_SIZE - 1);
        rq.cmd        = CMD_LOOKUP;
        rq.hash       = pool_hash[sel];
        rq.lock       = pool_lock[sel];
        rq.info       = pool_info[sel];
        rq.depth      = 8'($urandom_range(0, 14));
        rq.age        = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : cur_age;
        rq.bound      = 2'($urandom_range(0, 3));
        rq.score      = 16'($urandom);
        rq.move       = 16'($urandom);
        rq.search_age = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                     : cur_age;
        if (pick < 45)
        begin
            rq.cmd   = CMD_INSERT;
            rq.depth = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(1, 12));
        end
        else if (pick < 85)
        begin
            if ($urandom_range(0, 19) == 0)
                rq.depth = 8'hFF;
        end
        else if (pick < 86)
        begin
            rq.cmd = CMD_CLEAR;
        end
        else if (pick < 92)
        begin
            // Same slot chain, but one identity bit off.
            if ($urandom_range(0, 1) == 0)
                rq.info = rq.info ^ 8'(1 << $urandom_range(0, 7));
            else
                rq.lock = rq.lock ^ 32'(1 << $urandom_range(0, 31));
        end
        else if (pick < 98)
        begin
            rq.cmd        = 2'($urandom_range(0, 1));
            rq.hash       = {$urandom, $urandom};
            rq.lock       = $urandom;
            rq.info       = 8'($urandom);
            rq.depth      = 8'($urandom);
            rq.search_age = 8'($urandom);
        end
        else
        begin
            rq.cmd = CMD_UNKNOWN;
        end
        return rq;
    endfunction

    initial
    begin
        logic [3:0] probe_plan [PHASES];

        // The probe limits per phase: full, single, none, above the maximum, one in
        // between and another above the maximum; the last one is drawn at random.
        probe_plan = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd9, 4'($urandom_range(0, 15))};

        for (int k = 0; k < POOL_SIZE; k++)
        begin
            pool_hash[k] = {$urandom, $urandom};
            pool_hash[k][INDEX_BITS-1:0] = INDEX_BITS'(TABLE_SIZE - 8 + $urandom_range(0, 15));
            pool_lock[k] = $urandom;
            if (pool_lock[k] == '0)
                pool_lock[k] = 32'd1;
            pool_info[k] = 8'($urandom);
            // Every fourth position shares hash and lock with its neighbor and
            // differs only in the identity bits.
            if (k % 4 == 3)
            begin
                pool_hash[k] = pool_hash[k-1];
                pool_lock[k] = pool_lock[k-1];
                pool_info[k] = pool_info[k-1] ^ 8'h5A;
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset probe limit of four.
        // A lookup on the empty table misses.
        send_request(make_request(CMD_LOOKUP, '0, 32'd1, 8'd0, 8'd0, 8'd0, 2'd0,
                                  16'd0, 16'd0, 8'd0));
        // All ones at the last slot, then a second entry that wraps to slot 0.
        send_request(make_request(CMD_INSERT, '1, '1, '1, '1, '1, 2'd3, 16'h8000,
                                  '1, 8'd0));
        send_request(make_request(CMD_INSERT, '1, 32'h1234, 8'd0, 8'd1, 8'd0, 2'd0,
                                  16'h7FFF, 16'd0, 8'd0));
        // Deep enough, too shallow, identity off by the info bits, zero lock.
        send_request(make_request(CMD_LOOKUP, '1, '1, '1, '1, 8'd0, 2'd0, 16'd0,
                                  16'd0, 8'd0));
        send_request(make_request(CMD_LOOKUP, '1, 32'h1234, 8'd0, 8'd2, 8'd0, 2'd0,
                                  16'd0, 16'd0, 8'd0));
        send_request(make_request(CMD_LOOKUP, '1, '1, 8'hFE, 8'd0, 8'd0, 2'd0,
                                  16'd0, 16'd0, 8'd0));
        send_request(make_request(CMD_LOOKUP, '1, 32'd0, 8'd0, 8'd0, 8'd0, 2'd0,
                                  16'd0, 16'd0, 8'd0));
        // Fill four slots, then force out the shallowest one.
        for (int k = 0; k < 4; k++)
            send_request(make_request(CMD_INSERT, 64'h40, 32'hA1 + k, 8'd0,
                                      8'(5 - 2 * (k % 2) + 2 * k), 8'd10, 2'(k),
                                      16'(100 * k), 16'(k), 8'd0));
        send_request(make_request(CMD_INSERT, 64'h40, 32'hB1, 8'd7, 8'd2, 8'd10,
                                  2'd1, 16'hFF00, 16'h00B1, 8'd0));
        send_request(make_request(CMD_LOOKUP, 64'h40, 32'hB1, 8'd7, 8'd2, 8'd0,
                                  2'd0, 16'd0, 16'd0, 8'd0));
        // A stale entry gives way, then the same position at equal depth.
        send_request(make_request(CMD_INSERT, 64'h40, 32'hC1, 8'd3, 8'd1, 8'd11,
                                  2'd2, 16'd77, 16'h00C1, 8'd11));
        send_request(make_request(CMD_INSERT, 64'h40, 32'hC1, 8'd3, 8'd1, 8'd12,
                                  2'd0, 16'd78, 16'h00C2, 8'd0));
        // Unknown command with every bit set, then an all-zero insert.
        send_request(make_request(CMD_UNKNOWN, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        send_request(make_request(CMD_INSERT, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        // Clear, then the deep entry must be gone.
        send_request(make_request(CMD_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_request(make_request(CMD_LOOKUP, '1, '1, '1, '1, 8'd0, 2'd0, 16'd0,
                                  16'd0, 8'd0));
        // No probes at all: the insert fails and the lookup finds nothing.
        write_probe_limit(4'd0);
        send_request(make_request(CMD_INSERT, 64'h80, 32'h55, 8'd1, 8'd9, 8'd1,
                                  2'd1, 16'd5, 16'd5, 8'd0));
        send_request(make_request(CMD_LOOKUP, 64'h80, 32'h55, 8'd1, 8'd0, 8'd0,
                                  2'd0, 16'd0, 16'd0, 8'd0));
        // A limit above the maximum acts as the maximum.
        write_probe_limit(4'd15);
        send_request(make_request(CMD_INSERT, 64'h40, 32'hD1, 8'd0, 8'd3, 8'd12,
                                  2'd2, 16'd9, 16'h00D1, 8'd0));
        send_request(make_request(CMD_LOOKUP, 64'h40, 32'hD1, 8'd0, 8'd3, 8'd0,
                                  2'd0, 16'd0, 16'd0, 8'd0));

        // Random part, one probe limit per phase.
        for (int p = 0; p < PHASES; p++)
        begin
            write_probe_limit(probe_plan[p]);
            idle_on = (p != 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Let the whole pipeline run dry once mid-phase.
                if (p == 3 && n == 100)
                    wait_results_drained();
                if (n % 80 == 79)
                    cur_age = cur_age + 8'($urandom_range(1, 3));
                send_request(random_request());
            end
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (table_model.mismatches == 0 && table_model.outstanding() == 0)
            $display("[transposition_table_probe_replace] OK");
        else
            $display("[transposition_table_probe_replace] ERROR");
        $finish;
    end

endmodule
